// ===== hdl/vsmc_pkg.sv =====
// Shared types and constants for the voice session mode controller.
// No dependencies; every other file imports this package.
package vsmc_pkg;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_AW      = 3;
  localparam int CFG_W       = 12;
  localparam int CD_W        = 11;

  // divide-by-constant unit for the retry countdown: exact for dividends below 2**DIV_W
  localparam int DIV_W  = 13;
  localparam int DIV_SH = 20;
  localparam int RECIP_W = DIV_SH + 1;
  localparam int CD_MAX = 1023;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_LISTEN_TO = 3'd0;
  localparam logic [CFG_AW-1:0] REG_THINK_TO  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_LINGER    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_RETRY     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_TEXT_ONLY = 3'd4;

  localparam logic [CFG_W-1:0] LISTEN_TO_RST = 12'd100;
  localparam logic [CFG_W-1:0] THINK_TO_RST  = 12'd120;
  localparam logic [CFG_W-1:0] LINGER_RST    = 12'd240;
  localparam logic [CFG_W-1:0] RETRY_RST     = 12'd40;
  localparam logic [CFG_W-1:0] TEXT_ONLY_RST = 12'd2;

  // event codes on the mode field
  localparam logic [4:0] MODE_TICK          = 5'd0;
  localparam logic [4:0] MODE_PORTAL        = 5'd1;
  localparam logic [4:0] MODE_AUTH_OK       = 5'd2;
  localparam logic [4:0] MODE_AUTH_BAD      = 5'd3;
  localparam logic [4:0] MODE_WIFI_DOWN     = 5'd4;
  localparam logic [4:0] MODE_WAKE          = 5'd5;
  localparam logic [4:0] MODE_SPEECH_START  = 5'd6;
  localparam logic [4:0] MODE_SPEECH_STOP   = 5'd7;
  localparam logic [4:0] MODE_RESP_START    = 5'd8;
  localparam logic [4:0] MODE_RESP_DONE     = 5'd9;
  localparam logic [4:0] MODE_LINK_CLOSED   = 5'd10;
  localparam logic [4:0] MODE_LINK_ERROR    = 5'd11;
  localparam logic [4:0] MODE_STOP          = 5'd12;
  localparam logic [4:0] MODE_CANCEL        = 5'd13;
  localparam logic [4:0] MODE_FINISH        = 5'd14;
  localparam logic [4:0] MODE_SETTINGS_OPEN = 5'd15;
  localparam logic [4:0] MODE_SETTINGS_SHUT = 5'd16;
  localparam logic [4:0] MODE_RETRY         = 5'd17;
  localparam logic [4:0] MODE_WIFI_SETUP    = 5'd18;

  typedef enum logic [2:0] {
    ST_BOOT   = 3'd0,
    ST_PROV   = 3'd1,
    ST_IDLE   = 3'd2,
    ST_LISTEN = 3'd3,
    ST_THINK  = 3'd4,
    ST_SPEAK  = 3'd5,
    ST_CONFIG = 3'd6,
    ST_ERROR  = 3'd7
  } state_t;

  typedef enum logic [4:0] {
    EV_NONE,
    EV_TICK,
    EV_PORTAL,
    EV_AUTH_OK,
    EV_AUTH_BAD,
    EV_WIFI_DOWN,
    EV_WAKE,
    EV_SPEECH_START,
    EV_SPEECH_END,
    EV_RESP_START,
    EV_RESP_DONE,
    EV_LINK_CLOSED,
    EV_LINK_FATAL,
    EV_STOP,
    EV_CANCEL,
    EV_CFG_OPEN,
    EV_CFG_CLOSE,
    EV_RETRY,
    EV_WIFI_SETUP
  } ev_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_START_FAILED = 3'd1,
    ERR_WIFI_LOST    = 3'd2,
    ERR_LINK_CLOSED  = 3'd3,
    ERR_LINK_FATAL   = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    TELE_NONE        = 2'd0,
    TELE_WAKE        = 2'd1,
    TELE_BARGE_WAKE  = 2'd2,
    TELE_BARGE_TOUCH = 2'd3
  } tele_t;

  // input beat, last field in the lowest bits
  typedef struct packed {
    logic       link_start_ok;
    logic       link_running;
    logic       net_paired;
    logic       net_online;
    logic       audio_playing;
    logic       fatal_flag;
    logic [4:0] mode;
  } in_t;

  // classified item handed from front to back
  typedef struct packed {
    ev_t  ev;
    logic playing;
    logic online;
    logic paired;
    logic running;
    logic start_ok;
  } qitem_t;

  // result beat, last field in the lowest bits
  typedef struct packed {
    tele_t                  telemetry_kind;
    logic signed [CD_W-1:0] countdown_seconds;
    logic                   countdown_update;
    err_t                   error_kind;
    logic                   save_and_report;
    logic                   cancel_flush;
    logic                   stop_link;
    logic                   start_link;
    logic                   state_changed;
    state_t                 prev_state;
    state_t                 app_state;
  } res_t;

  localparam int IN_W  = $bits(in_t);
  localparam int RES_W = $bits(res_t);

  function automatic logic in_dialogue(input state_t s);
    return (s == ST_LISTEN) || (s == ST_THINK) || (s == ST_SPEAK);
  endfunction

endpackage

// ===== hdl/vsmc_front.sv =====
// Front stage: takes input beats, decodes the event code and registers a classified item.
// Depends on vsmc_pkg.
module vsmc_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [vsmc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               item_valid,
  input  logic                               item_ready,
  output vsmc_pkg::qitem_t                   item
);
  import vsmc_pkg::*;

  in_t    beat;
  ev_t    ev;
  logic   vld;
  qitem_t held;

  assign beat = in_t'(s_axis_tdata[IN_W-1:0]);

  always_comb begin
    unique case (beat.mode)
      MODE_TICK:          ev = EV_TICK;
      MODE_PORTAL:        ev = EV_PORTAL;
      MODE_AUTH_OK:       ev = EV_AUTH_OK;
      MODE_AUTH_BAD:      ev = EV_AUTH_BAD;
      MODE_WIFI_DOWN:     ev = EV_WIFI_DOWN;
      MODE_WAKE:          ev = EV_WAKE;
      MODE_SPEECH_START:  ev = EV_SPEECH_START;
      MODE_SPEECH_STOP:   ev = EV_SPEECH_END;
      MODE_FINISH:        ev = EV_SPEECH_END;
      MODE_RESP_START:    ev = EV_RESP_START;
      MODE_RESP_DONE:     ev = EV_RESP_DONE;
      MODE_LINK_CLOSED:   ev = EV_LINK_CLOSED;
      // a non-fatal link error does nothing
      MODE_LINK_ERROR:    ev = beat.fatal_flag ? EV_LINK_FATAL : EV_NONE;
      MODE_STOP:          ev = EV_STOP;
      MODE_CANCEL:        ev = EV_CANCEL;
      MODE_SETTINGS_OPEN: ev = EV_CFG_OPEN;
      MODE_SETTINGS_SHUT: ev = EV_CFG_CLOSE;
      MODE_RETRY:         ev = EV_RETRY;
      MODE_WIFI_SETUP:    ev = EV_WIFI_SETUP;
      default:            ev = EV_NONE;
    endcase
  end

  assign s_axis_tready = !vld || item_ready;
  assign item_valid    = vld;
  assign item          = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_axis_tready) begin
      vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      held.ev       <= ev;
      held.playing  <= beat.audio_playing;
      held.online   <= beat.net_online;
      held.paired   <= beat.net_paired;
      held.running  <= beat.link_running;
      held.start_ok <= beat.link_start_ok;
    end
  end

endmodule

// ===== hdl/vsmc_queue.sv =====
// Short register queue between the front and back stages.
// Depends on vsmc_pkg for the item type.
module vsmc_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  vsmc_pkg::qitem_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output vsmc_pkg::qitem_t pop_item
);
  import vsmc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  qitem_t          entries [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== hdl/vsmc_exec.sv =====
// Back stage: mode state, tick timer, retry countdown, config registers, result register.
// Depends on vsmc_pkg.
module vsmc_exec #(
  parameter int TICKS_PER_SECOND = 4,
  parameter int TIMER_BITS       = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  vsmc_pkg::qitem_t                    item,
  input  logic                                cfg_we,
  input  logic [vsmc_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [vsmc_pkg::CFG_W-1:0]          cfg_wdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [vsmc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import vsmc_pkg::*;

  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam int NUM_W = CMP_W + 2;
  localparam longint RECIP = ((64'sd1 <<< DIV_SH) + TICKS_PER_SECOND - 1) / TICKS_PER_SECOND;
  localparam int NEG_TPS = -TICKS_PER_SECOND;
  localparam int Q_W = DIV_W + RECIP_W - DIV_SH;

  // configuration
  logic [CFG_W-1:0] listen_to, think_to, linger, retry, text_only;

  // control state
  state_t                  state, state_next;
  logic [TIMER_BITS-1:0]   ticks, ticks_next;
  logic                    resp_done, resp_done_next;
  logic signed [CD_W-1:0]  last_cd, last_cd_next;

  logic                    out_valid;
  res_t                    out_data;
  res_t                    res;
  logic                    take;

  // helpers
  logic [TIMER_BITS-1:0]   ticks_inc;
  logic [CMP_W-1:0]        t_cmp;
  logic signed [NUM_W-1:0] num;
  logic [DIV_W-1:0]        dividend;
  logic [DIV_W+RECIP_W-1:0] prod;
  logic [Q_W-1:0]          quot;
  logic signed [CD_W-1:0]  quot_sat;
  logic signed [CD_W-1:0]  cd_tick;
  logic                    go, listen_req;
  state_t                  tgt;

  assign item_ready = !out_valid || m_axis_tready;
  assign take       = item_valid && item_ready;

  assign ticks_inc = (&ticks) ? ticks : ticks + 1'b1;
  assign t_cmp     = CMP_W'(ticks_inc);

  // countdown: ceil((retry - t) / TPS) by reciprocal multiply; seed shares the multiplier
  assign num = $signed(NUM_W'(retry)) - $signed(NUM_W'(t_cmp))
             + $signed(NUM_W'(TICKS_PER_SECOND - 1));
  assign dividend = (item.ev == EV_TICK) ? num[DIV_W-1:0] : DIV_W'(retry);
  assign prod     = dividend * RECIP_W'(RECIP);
  assign quot     = prod[DIV_W+RECIP_W-1:DIV_SH];
  assign quot_sat = (quot > Q_W'(CD_MAX)) ? CD_W'(CD_MAX) : CD_W'(quot);

  always_comb begin
    if (!num[NUM_W-1]) begin
      cd_tick = quot_sat;
    end else if (num > $signed(NUM_W'(NEG_TPS))) begin
      cd_tick = '0;  // small negative numerator truncates to zero
    end else begin
      cd_tick = '1;
    end
  end

  always_comb begin
    state_next     = state;
    ticks_next     = ticks;
    resp_done_next = resp_done;
    last_cd_next   = last_cd;
    go             = 1'b0;
    tgt            = state;
    listen_req     = 1'b0;

    res                   = '0;
    res.prev_state        = state;
    res.error_kind        = ERR_NONE;
    res.telemetry_kind    = TELE_NONE;
    res.countdown_seconds = '1;

    unique case (item.ev)
      EV_TICK: begin
        ticks_next = ticks_inc;
        unique case (state)
          ST_THINK: begin
            if (item.playing) begin
              go = 1'b1; tgt = ST_SPEAK;
            end else if (resp_done && t_cmp > CMP_W'(text_only)) begin
              resp_done_next = 1'b0;
              go = 1'b1; tgt = ST_IDLE;
            end else if (t_cmp > CMP_W'(think_to)) begin
              go = 1'b1; tgt = ST_IDLE;
            end
          end
          ST_SPEAK: begin
            if (resp_done && !item.playing) begin
              resp_done_next = 1'b0;
              go = 1'b1; tgt = ST_IDLE;
            end
          end
          ST_LISTEN: begin
            if (t_cmp > CMP_W'(listen_to)) begin
              go = 1'b1; tgt = ST_IDLE;
            end
          end
          ST_IDLE: begin
            res.stop_link = item.running && (t_cmp > CMP_W'(linger));
          end
          ST_ERROR: begin
            if (t_cmp > CMP_W'(retry) && item.online && item.paired) begin
              go = 1'b1; tgt = ST_IDLE;
            end else if (cd_tick != last_cd) begin
              last_cd_next          = cd_tick;
              res.countdown_update  = 1'b1;
              res.countdown_seconds = cd_tick;
            end
          end
          default: ;
        endcase
      end
      EV_PORTAL: begin
        if (!in_dialogue(state) && state != ST_CONFIG) begin
          go = 1'b1; tgt = ST_PROV;
        end
      end
      EV_AUTH_OK: begin
        if (state == ST_BOOT || state == ST_PROV || state == ST_ERROR) begin
          go = 1'b1; tgt = ST_IDLE;
        end
      end
      EV_AUTH_BAD: begin
        res.stop_link = 1'b1;
        go = 1'b1; tgt = ST_PROV;
      end
      EV_WIFI_DOWN: begin
        if (in_dialogue(state)) begin
          res.stop_link  = 1'b1;
          res.error_kind = ERR_WIFI_LOST;
          go = 1'b1; tgt = ST_ERROR;
        end
      end
      EV_WAKE: begin
        if (state == ST_IDLE) begin
          res.telemetry_kind = TELE_WAKE;
          listen_req = 1'b1;
        end else if (state == ST_SPEAK) begin
          res.cancel_flush   = 1'b1;
          res.telemetry_kind = TELE_BARGE_WAKE;
          listen_req = 1'b1;
        end
      end
      EV_SPEECH_START: begin
        if (state == ST_SPEAK || state == ST_THINK) begin
          resp_done_next = 1'b0;
          go = 1'b1; tgt = ST_LISTEN;
        end else if (state == ST_LISTEN) begin
          ticks_next = '0;
        end
      end
      EV_SPEECH_END: begin
        if (state == ST_LISTEN) begin
          go = 1'b1; tgt = ST_THINK;
        end
      end
      EV_RESP_START: begin
        resp_done_next = 1'b0;
        if (state == ST_LISTEN) begin
          go = 1'b1; tgt = ST_THINK;
        end
      end
      EV_RESP_DONE: resp_done_next = 1'b1;
      EV_LINK_CLOSED: begin
        if (in_dialogue(state)) begin
          res.error_kind = ERR_LINK_CLOSED;
          go = 1'b1; tgt = ST_ERROR;
        end
      end
      EV_LINK_FATAL: begin
        if (in_dialogue(state)) begin
          res.error_kind = ERR_LINK_FATAL;
          go = 1'b1; tgt = ST_ERROR;
        end
      end
      EV_STOP: begin
        if (state == ST_SPEAK) begin
          res.cancel_flush   = 1'b1;
          res.telemetry_kind = TELE_BARGE_TOUCH;
          listen_req = 1'b1;
        end else if (state == ST_LISTEN || state == ST_THINK) begin
          res.cancel_flush = 1'b1;
          go = 1'b1; tgt = ST_IDLE;
        end
      end
      EV_CANCEL: begin
        if (in_dialogue(state)) begin
          res.cancel_flush = 1'b1;
          go = 1'b1; tgt = ST_IDLE;
        end
      end
      EV_CFG_OPEN: begin
        if (state == ST_IDLE) begin
          go = 1'b1; tgt = ST_CONFIG;
        end
      end
      EV_CFG_CLOSE: begin
        if (state == ST_CONFIG) begin
          res.save_and_report = 1'b1;
          go = 1'b1; tgt = ST_IDLE;
        end
      end
      EV_RETRY: begin
        if (state == ST_ERROR && item.online && item.paired) begin
          go = 1'b1; tgt = ST_IDLE;
        end
      end
      EV_WIFI_SETUP: res.stop_link = 1'b1;
      default: ;
    endcase

    // session start for wake and touch barge-in
    if (listen_req) begin
      res.start_link = !item.running;
      if (!item.running && !item.start_ok) begin
        res.error_kind = ERR_START_FAILED;
        go = 1'b1; tgt = ST_ERROR;
      end else begin
        resp_done_next = 1'b0;
        go = 1'b1; tgt = ST_LISTEN;
      end
    end

    if (go && tgt != state) begin
      state_next = tgt;
      ticks_next = '0;
      if (state == ST_ERROR) begin
        res.countdown_update  = 1'b1;
        res.countdown_seconds = '1;
      end
      if (tgt == ST_ERROR) begin
        last_cd_next          = quot_sat;
        res.countdown_update  = 1'b1;
        res.countdown_seconds = quot_sat;
      end
    end

    res.app_state     = state_next;
    res.state_changed = (state_next != state);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_BOOT;
      ticks     <= '0;
      resp_done <= 1'b0;
      last_cd   <= '1;
    end else if (take) begin
      state     <= state_next;
      ticks     <= ticks_next;
      resp_done <= resp_done_next;
      last_cd   <= last_cd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_to <= LISTEN_TO_RST;
      think_to  <= THINK_TO_RST;
      linger    <= LINGER_RST;
      retry     <= RETRY_RST;
      text_only <= TEXT_ONLY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LISTEN_TO: listen_to <= cfg_wdata;
        REG_THINK_TO:  think_to  <= cfg_wdata;
        REG_LINGER:    linger    <= cfg_wdata;
        REG_RETRY:     retry     <= cfg_wdata;
        REG_TEXT_ONLY: text_only <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_ready) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data);

endmodule

// ===== hdl/voice_session_mode_controller_unit.sv =====
// Voice session mode controller, top level: front decode, item queue, back state stage.
// Depends on vsmc_pkg, vsmc_front, vsmc_queue and vsmc_exec.
//
// Usage:
//   Event beats enter on s_axis (tdata: mode, fatal_flag, audio_playing, net_online,
//   net_paired, link_running, link_start_ok). Each beat yields exactly one result beat
//   on m_axis with the new and previous mode, action strobes, error kind and the retry
//   countdown shown. Timeout registers are written on cfg_we/cfg_addr/cfg_wdata while
//   no beat is in flight.
//   An input beat passes the decode register, the two-entry queue and the result
//   register. One beat per cycle is sustained while m_axis_tready stays high; the mode
//   state, tick counter and countdown are updated together in the back stage, whose
//   longest path is the tick increment into the countdown reciprocal multiplier.
//   Reset (synchronous, rst high) returns the mode to boot, clears the tick counter and
//   the response-done flag, hides the countdown and loads the default timeouts.
//   If m_axis_tready is held low the result register holds its beat, the queue fills
//   and s_axis_tready drops after at most three further beats are taken.
module voice_session_mode_controller_unit #(
  parameter int TICKS_PER_SECOND = 4,
  parameter int TIMER_BITS       = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [4:0] mode, [5] fatal_flag, [6] audio_playing, [7] net_online, [8] net_paired,
  // [9] link_running, [10] link_start_ok, [15:11] zero
  input  logic [vsmc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [2:0] app_state, [5:3] prev_state, [6] state_changed, [7] start_link, [8] stop_link,
  // [9] cancel_flush, [10] save_and_report, [13:11] error_kind, [14] countdown_update,
  // [25:15] countdown_seconds, [27:26] telemetry_kind, [31:28] zero
  output logic [vsmc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_we,
  input  logic [vsmc_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [vsmc_pkg::CFG_W-1:0]         cfg_wdata
);
  import vsmc_pkg::*;

  logic   f_valid, f_ready;
  qitem_t f_item;
  logic   q_valid, q_ready;
  qitem_t q_item;

  vsmc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .item_valid    (f_valid),
    .item_ready    (f_ready),
    .item          (f_item)
  );

  vsmc_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  vsmc_exec #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .TIMER_BITS       (TIMER_BITS)
  ) u_exec (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (q_valid),
    .item_ready    (q_ready),
    .item          (q_item),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== hdl/vsmc_checker.sv =====
// Port-level checks for the voice session mode controller, bound to the top level.
// Depends on vsmc_pkg and voice_session_mode_controller_unit.
module vsmc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [vsmc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import vsmc_pkg::*;

  res_t r;
  assign r = res_t'(m_axis_tdata[RES_W-1:0]);

  // nothing on the result side straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat valid after reset");

  // a stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  a_changed_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (r.state_changed == (r.app_state != r.prev_state)))
    else $error("state_changed disagrees with states");

  a_hidden_cd: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !r.countdown_update |-> (&r.countdown_seconds))
    else $error("countdown shown without update");

  // any reported error lands in the error mode with a fresh countdown
  a_err_mode: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (r.error_kind != ERR_NONE)
      |-> (r.app_state == ST_ERROR) && r.countdown_update && r.state_changed)
    else $error("error reported outside error mode");

endmodule

bind voice_session_mode_controller_unit vsmc_checker u_vsmc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
